### rtl/rid_pkg.sv
// Shared types and constants for the recent-ID list with seen counts.
// Holds item, result and list-entry structs and the walk control bundle.
// No dependencies.
`default_nettype none

package rid_pkg;

    localparam int AddrW = 24;
    localparam int TimeW = 32;
    localparam int CntW  = 10;
    localparam int HourW = 5;
    localparam int SpanW = 17;

    localparam logic [TimeW-1:0] HourSec  = 32'd3600;
    localparam logic [CntW-1:0]  CntOvf   = 10'd999;
    localparam logic [6:0]       DayHours = 7'd24;

    typedef struct packed {
        logic             mode;
        logic [AddrW-1:0] addr;
        logic [TimeW-1:0] seen_time;
        logic             hidden;
        logic [TimeW-1:0] now_time;
        logic [HourW-1:0] utc_hour;
    } t_in_item;

    typedef struct packed {
        logic            was_listed;
        logic [CntW-1:0] seen_ever;
        logic [CntW-1:0] seen_today;
        logic [CntW-1:0] seen_hour;
        logic [CntW-1:0] visible_hour;
    } t_out_item;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [TimeW-1:0] stamp;
        logic             hidden;
    } t_entry;

    typedef struct packed {
        logic start;
        logic step;
        logic last;
    } t_walk_ctl;

endpackage

`default_nettype wire

### rtl/rid_cell.sv
// One list cell: holds one recency position of the ID list.
// Shifts in its neighbor's entry while the list rotates. Uses rid_pkg.
`default_nettype none

module rid_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire rid_pkg::t_entry i_d,
    output rid_pkg::t_entry     o_q
);

    logic [rid_pkg::AddrW-1:0] r_addr;
    logic [rid_pkg::TimeW-1:0] r_stamp;
    logic                      r_hidden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_shift) begin
            r_addr <= i_d.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_stamp  <= i_d.stamp;
            r_hidden <= i_d.hidden;
        end
    end

    assign o_q.addr   = r_addr;
    assign o_q.stamp  = r_stamp;
    assign o_q.hidden = r_hidden;

endmodule

`default_nettype wire

### rtl/rid_head.sv
// Head unit of the list ring: sees one entry per cycle as the list rotates.
// Does move-to-front on observe beats and the seen counts on count beats. Uses rid_pkg.
`default_nettype none

module rid_head (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rid_pkg::t_walk_ctl   i_ctl,
    input  wire rid_pkg::t_in_item    i_item,
    input  wire logic signed [4:0]    i_tz,
    input  wire logic                 i_last_used,
    input  wire rid_pkg::t_entry      i_cur,
    output rid_pkg::t_entry           o_wr,
    output rid_pkg::t_out_item        o_res
);

    function automatic logic [rid_pkg::CntW-1:0] sat_inc(input logic [rid_pkg::CntW-1:0] c);
        sat_inc = (c == rid_pkg::CntOvf) ? c : c + 1'b1;
    endfunction

    logic                      r_mode, n_mode;
    logic [rid_pkg::AddrW-1:0] r_key, n_key;
    rid_pkg::t_entry           r_carry, n_carry;
    logic                      r_done, n_done;
    logic                      r_listed, n_listed;
    logic                      r_stop, n_stop;
    logic                      r_last_used, n_last_used;
    logic [rid_pkg::TimeW-1:0] r_day_cut, n_day_cut;
    logic [rid_pkg::TimeW-1:0] r_hour_cut, n_hour_cut;
    logic [rid_pkg::CntW-1:0]  r_ever, n_ever;
    logic [rid_pkg::CntW-1:0]  r_today, n_today;
    logic [rid_pkg::CntW-1:0]  r_hour, n_hour;
    logic [rid_pkg::CntW-1:0]  r_vis, n_vis;

    logic signed [6:0]         w_sum;
    logic signed [6:0]         w_wrap_hi;
    logic signed [6:0]         w_local;
    logic [rid_pkg::HourW-1:0] w_hour_idx;
    logic [rid_pkg::SpanW-1:0] w_span;
    logic                      w_early;
    logic                      w_match;
    logic                      w_empty;
    logic                      w_in_day;

    // local hour and day span
    assign w_sum      = $signed({2'b00, i_item.utc_hour}) + $signed({{2{i_tz[4]}}, i_tz});
    assign w_wrap_hi  = (w_sum > $signed(7'd23)) ? w_sum - $signed(rid_pkg::DayHours) : w_sum;
    assign w_local    = (w_wrap_hi < $signed(7'd0)) ? w_wrap_hi + $signed(rid_pkg::DayHours)
                                                    : w_wrap_hi;
    assign w_hour_idx = w_local[rid_pkg::HourW-1:0];
    assign w_span     = rid_pkg::SpanW'(({27'd0, w_hour_idx} + 32'd1) * rid_pkg::HourSec);
    assign w_early    = i_item.now_time < {15'd0, w_span};

    assign w_match  = (i_cur.addr == r_key);
    assign w_empty  = (i_cur.addr == '0);
    assign w_in_day = (i_cur.stamp > r_day_cut);

    always_comb begin
        n_mode      = r_mode;
        n_key       = r_key;
        n_carry     = r_carry;
        n_done      = r_done;
        n_listed    = r_listed;
        n_stop      = r_stop;
        n_last_used = r_last_used;
        n_day_cut   = r_day_cut;
        n_hour_cut  = r_hour_cut;
        n_ever      = r_ever;
        n_today     = r_today;
        n_hour      = r_hour;
        n_vis       = r_vis;
        o_wr        = i_cur;
        if (i_ctl.start) begin
            n_mode         = i_item.mode;
            n_key          = i_item.addr;
            n_carry.addr   = i_item.addr;
            n_carry.stamp  = i_item.seen_time;
            n_carry.hidden = i_item.hidden;
            n_done         = (i_item.addr == '0);
            n_listed       = 1'b0;
            n_stop         = w_early;
            n_last_used    = i_last_used;
            n_day_cut      = i_item.now_time - {15'd0, w_span};
            n_hour_cut     = i_item.now_time - rid_pkg::HourSec;
            n_ever         = '0;
            n_today        = '0;
            n_hour         = '0;
            n_vis          = '0;
        end else if (i_ctl.step) begin
            if (!r_mode) begin
                if (!r_done) begin
                    o_wr = r_carry;
                    if (w_match || w_empty || i_ctl.last) begin
                        n_done   = 1'b1;
                        n_listed = w_match;
                    end else begin
                        n_carry = i_cur;
                    end
                end
            end else if (!r_stop) begin
                if (w_empty) begin
                    n_stop = 1'b1;
                end else begin
                    n_ever = sat_inc(r_ever);
                    if (w_in_day) begin
                        n_today = sat_inc(r_today);
                        if (i_cur.stamp > r_hour_cut) begin
                            n_hour = sat_inc(r_hour);
                            if (!i_cur.hidden) begin
                                n_vis = sat_inc(r_vis);
                            end
                        end
                    end
                    if (!w_in_day && r_last_used) begin
                        n_ever = rid_pkg::CntOvf;
                        n_stop = 1'b1;
                    end else if (i_ctl.last) begin
                        n_ever  = rid_pkg::CntOvf;
                        n_today = rid_pkg::CntOvf;
                        n_stop  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_done   <= 1'b1;
            r_stop   <= 1'b1;
            r_listed <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_done   <= n_done;
            r_stop   <= n_stop;
            r_listed <= n_listed;
        end
        r_key       <= n_key;
        r_carry     <= n_carry;
        r_last_used <= n_last_used;
        r_day_cut   <= n_day_cut;
        r_hour_cut  <= n_hour_cut;
        r_ever      <= n_ever;
        r_today     <= n_today;
        r_hour      <= n_hour;
        r_vis       <= n_vis;
    end

    assign o_res.was_listed   = r_listed;
    assign o_res.seen_ever    = r_ever;
    assign o_res.seen_today   = r_today;
    assign o_res.seen_hour    = r_hour;
    assign o_res.visible_hour = r_vis;

endmodule

`default_nettype wire

### rtl/recent_id_list_with_counts.sv
// Recent-ID list with seen counts: top level, a ring of LIST_DEPTH list cells and one head unit.
// Instantiates rid_cell and rid_head; uses rid_pkg.
// After accept, the whole list rotates once through the ring of cells past the head unit,
// which handles one recency position per cycle, then the result is loaded into the output
// register. A new item is taken only while the ring is at rest, at the earliest in the cycle
// after that load; a finished result may still wait at the output while the next item walks,
// and a walk that ends while the output register is still full holds until it drains.
// Reset empties the list at once; the timezone register may be written at any idle time.
`default_nettype none

module recent_id_list_with_counts #(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [4:0]        i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rid_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rid_pkg::t_out_item     o_out_data
);

    localparam int PosW = $clog2(LIST_DEPTH);
    localparam logic [PosW-1:0] PosLast = PosW'(LIST_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [PosW-1:0]     r_pos;
    logic                r_out_valid;
    rid_pkg::t_out_item  r_out_data;
    logic signed [4:0]   r_tz;

    rid_pkg::t_entry     w_cell [LIST_DEPTH];
    rid_pkg::t_entry     w_wr;
    rid_pkg::t_out_item  w_res;
    rid_pkg::t_walk_ctl  w_ctl;
    logic                w_in_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_ctl.start = w_in_acc;
    assign w_ctl.step  = (r_state == ST_WALK);
    assign w_ctl.last  = (r_pos == PosLast);

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            if (g == LIST_DEPTH - 1) begin : g_tail
                rid_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_ctl.step),
                    .i_d     (w_wr),
                    .o_q     (w_cell[g])
                );
            end else begin : g_body
                rid_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_ctl.step),
                    .i_d     (w_cell[g+1]),
                    .o_q     (w_cell[g])
                );
            end
        end
    endgenerate

    rid_head u_head (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_item      (i_in_data),
        .i_tz        (r_tz),
        .i_last_used (w_cell[LIST_DEPTH-1].addr != '0),
        .i_cur       (w_cell[0]),
        .o_wr        (w_wr),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= '0;
        end else if (i_cfg_wr_en) begin
            r_tz <= $signed(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_pos   <= '0;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_pos <= r_pos + 1'b1;
                    if (w_ctl.last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data  <= w_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_WALK) && (r_pos == '0))
        else $error("walk did not start at position zero after accept");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) && w_ctl.last |=> (r_state == ST_DONE))
        else $error("walk did not end after the last position");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the done state");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) && !w_ctl.last |=> !o_in_ready)
        else $error("input ready while the list is rotating");

endmodule

`default_nettype wire
